>>> rtl/assert_macros.svh
// assertion macros included by the tile top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define Q4MV_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("q4mv assertion failed");

// next-cycle implication, checked out of reset
`define Q4MV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("q4mv assertion failed");

`endif

>>> rtl/q4mv_pkg.sv
// shared constants and types of the q4 x int8 matvec tile
`timescale 1ns / 1ps
package q4mv_pkg;
  localparam int ROWS  = 8;
  localparam int ROW_W = $clog2(ROWS);
  localparam int DOT_W = 18;
  localparam int IN_W  = 480;
  localparam int OUT_W = 40;
  localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;

  // state handed from one row cell to the next
  typedef struct packed {
    logic signed [DOT_W-1:0] dot;
    logic [31:0]             acc;
  } link_t;

  // one row's work for the float unit
  typedef struct packed {
    logic signed [DOT_W-1:0] dot;
    logic [15:0]             row_scale;
    logic [31:0]             act_scale;
    logic [31:0]             acc;
  } fpu_req_t;
endpackage

>>> rtl/q4mv_cell.sv
// one row cell: integer group dot and fp32 accumulator of a weight row
`timescale 1ns / 1ps
module q4mv_cell import q4mv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        add_en,
  input  logic        shift_en,
  input  logic [63:0] acts,
  input  logic [31:0] wrow,
  input  link_t       link_in,
  output link_t       link_out
);
  logic signed [DOT_W-1:0] dot_r;
  logic [31:0]             acc_r;
  logic signed [14:0]      dsum;
  logic [3:0]              nlo, nhi;
  logic signed [3:0]       wl, wh;
  logic signed [7:0]       al, ah;

  // nibble minus 8 is the nibble with its top bit flipped, read as signed
  always_comb begin
    dsum = '0;
    nlo  = '0;
    nhi  = '0;
    wl   = '0;
    wh   = '0;
    al   = '0;
    ah   = '0;
    for (int j = 0; j < 4; j++) begin
      nlo  = wrow[8*j +: 4];
      nhi  = wrow[8*j+4 +: 4];
      wl   = signed'({~nlo[3], nlo[2:0]});
      wh   = signed'({~nhi[3], nhi[2:0]});
      al   = signed'(acts[8*j +: 8]);
      ah   = signed'(acts[8*(j+4) +: 8]);
      dsum = dsum + 15'(wl) * 15'(al) + 15'(wh) * 15'(ah);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r <= '0;
      acc_r <= '0;
    end else if (shift_en) begin
      dot_r <= link_in.dot;
      acc_r <= link_in.acc;
    end else if (add_en) begin
      dot_r <= dot_r + DOT_W'(dsum);
    end
  end

  assign link_out.dot = dot_r;
  assign link_out.acc = acc_r;
endmodule

>>> rtl/q4mv_fpu.sv
// multi-cycle float unit: fp16 x fp32 scale, then fused multiply-add into fp32
`timescale 1ns / 1ps
module q4mv_fpu import q4mv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  fpu_req_t    req,
  output logic        done,
  output logic [31:0] result
);
  localparam int MW = 82;
  localparam int WW = 81;
  localparam int EW = 11;
  typedef logic signed [EW-1:0] exp_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SMUL, ST_NORM, ST_SHIFT, ST_DENORM, ST_ROUND, ST_FMUL, ST_ALIGN, ST_ADD
  } state_t;
  typedef enum logic [1:0] {SP_NONE, SP_NAN, SP_INF} spec_t;

  state_t          state_r;
  fpu_req_t        req_r;
  logic            phase_r, sign_r, zero_r, lost_r, ovf_r, psign_r, asign_r, done_r;
  spec_t           spec_r;
  logic [MW-1:0]   mraw_r, mnorm_r, sden_r;
  exp_t            etop_r, e_r, tx_r, ty_r, t_r;
  logic [6:0]      lz_r;
  logic [7:0]      expf_r;
  logic [31:0]     scale_r, result_r;
  logic [41:0]     xmag_r;
  logic [23:0]     ymag_r;
  logic [WW-1:0]   a_r, b_r;

  function automatic logic [6:0] lzc(input logic [MW-1:0] v);
    logic [6:0] n;
    logic       hit;
    n   = 7'(MW);
    hit = 1'b0;
    for (int i = MW - 1; i >= 0; i--) begin
      if (!hit && v[i]) begin
        n   = 7'(MW - 1 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [6:0] sat_sh(input exp_t d, input logic [6:0] lim);
    if (d < 0) return 7'd0;
    else if (d > exp_t'(lim)) return lim;
    else return d[6:0];
  endfunction

  // right shift with everything shifted out jammed into the lsb
  function automatic logic [WW-1:0] shr_jam(input logic [WW-1:0] v, input logic [6:0] sh);
    logic [WW-1:0] m;
    m = ~({WW{1'b1}} << sh);
    return (v >> sh) | {{(WW-1){1'b0}}, |(v & m)};
  endfunction

  // scale operands
  logic [4:0]  h_exp;
  logic [7:0]  a_exp, s_exp, c_exp;
  logic [10:0] h_mant;
  logic [23:0] a_mant, s_mant, c_mant;
  exp_t        h_lsb, a_lsb, s_lsb, c_lsb;
  logic        h_nan, h_inf, h_zero, a_nan, a_inf, a_zero;
  logic        smul_nan, smul_inf;
  logic [34:0] smul_prod;
  // fma operands
  logic        s_nan, s_inf, c_nan, c_inf, dot_neg, fm_psign, fm_nan, fm_inf, fm_isign;
  logic [17:0] dot_mag;
  logic [41:0] fm_prod;
  // align / add
  logic          xz, yz, same, a_ge, add_sign;
  exp_t          t_max, dx, dy;
  logic [MW-1:0] add_res;
  logic [WW-1:0] diff;
  // normalise / round
  logic [6:0]    lz_nxt, dsh;
  logic          dn_sub, g, st;
  logic [30:0]   pack, rnd;
  logic [31:0]   round_res;

  always_comb begin
    h_exp  = req_r.row_scale[14:10];
    a_exp  = req_r.act_scale[30:23];
    h_mant = {h_exp != '0, req_r.row_scale[9:0]};
    a_mant = {a_exp != '0, req_r.act_scale[22:0]};
    h_lsb  = (h_exp == '0) ? exp_t'(-24) : exp_t'(h_exp) - exp_t'(25);
    a_lsb  = (a_exp == '0) ? exp_t'(-149) : exp_t'(a_exp) - exp_t'(150);
    h_nan  = (&h_exp) && (|req_r.row_scale[9:0]);
    h_inf  = (&h_exp) && !(|req_r.row_scale[9:0]);
    h_zero = !(|req_r.row_scale[14:0]);
    a_nan  = (&a_exp) && (|req_r.act_scale[22:0]);
    a_inf  = (&a_exp) && !(|req_r.act_scale[22:0]);
    a_zero = !(|req_r.act_scale[30:0]);
    smul_nan  = h_nan || a_nan || (h_inf && a_zero) || (a_inf && h_zero);
    smul_inf  = h_inf || a_inf;
    smul_prod = 35'(h_mant) * 35'(a_mant);

    s_exp  = scale_r[30:23];
    c_exp  = req_r.acc[30:23];
    s_mant = {s_exp != '0, scale_r[22:0]};
    c_mant = {c_exp != '0, req_r.acc[22:0]};
    s_lsb  = (s_exp == '0) ? exp_t'(-149) : exp_t'(s_exp) - exp_t'(150);
    c_lsb  = (c_exp == '0) ? exp_t'(-149) : exp_t'(c_exp) - exp_t'(150);
    s_nan  = (&s_exp) && (|scale_r[22:0]);
    s_inf  = (&s_exp) && !(|scale_r[22:0]);
    c_nan  = (&c_exp) && (|req_r.acc[22:0]);
    c_inf  = (&c_exp) && !(|req_r.acc[22:0]);
    dot_neg  = req_r.dot[DOT_W-1];
    dot_mag  = dot_neg ? (~req_r.dot + 18'd1) : req_r.dot;
    fm_psign = dot_neg ^ scale_r[31];
    fm_nan   = s_nan || c_nan || (s_inf && (req_r.dot == '0))
               || (s_inf && c_inf && (fm_psign != req_r.acc[31]));
    fm_inf   = s_inf || c_inf;
    fm_isign = s_inf ? fm_psign : req_r.acc[31];
    fm_prod  = 42'(dot_mag) * 42'(s_mant);

    xz    = (xmag_r == '0);
    yz    = (ymag_r == '0);
    t_max = xz ? ty_r : (yz ? tx_r : ((tx_r > ty_r) ? tx_r : ty_r));
    dx    = t_max - tx_r;
    dy    = t_max - ty_r;

    same     = (psign_r == asign_r);
    a_ge     = (a_r >= b_r);
    diff     = a_ge ? (a_r - b_r) : (b_r - a_r);
    add_res  = same ? ({1'b0, a_r} + {1'b0, b_r}) : {1'b0, diff};
    add_sign = same ? psign_r : (a_ge ? psign_r : asign_r);
    // exact cancellation gives +0, two zeros keep a common sign
    if (add_res == '0) add_sign = psign_r & asign_r;

    lz_nxt = lzc(mraw_r);
    dn_sub = (e_r < exp_t'(-126));
    dsh    = dn_sub ? sat_sh(exp_t'(-126) - e_r, 7'(MW)) : 7'd0;

    pack = {expf_r, sden_r[80:58]};
    g    = sden_r[57];
    st   = (|sden_r[56:0]) || lost_r;
    rnd  = pack + 31'(g && (st || pack[0]));
    if (spec_r == SP_NAN)                round_res = F32_QNAN;
    else if (spec_r == SP_INF || ovf_r)  round_res = {sign_r, 8'hFF, 23'd0};
    else if (zero_r)                     round_res = {sign_r, 31'd0};
    else                                 round_res = {sign_r, rnd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          done_r <= 1'b0;
          if (start) begin
            req_r   <= req;
            state_r <= ST_SMUL;
          end
        end
        ST_SMUL: begin
          mraw_r  <= {smul_prod, 47'd0};
          etop_r  <= h_lsb + a_lsb + exp_t'(34);
          sign_r  <= req_r.row_scale[15] ^ req_r.act_scale[31];
          spec_r  <= smul_nan ? SP_NAN : (smul_inf ? SP_INF : SP_NONE);
          phase_r <= 1'b0;
          state_r <= ST_NORM;
        end
        ST_NORM: begin
          lz_r    <= lz_nxt;
          zero_r  <= (mraw_r == '0);
          state_r <= ST_SHIFT;
        end
        ST_SHIFT: begin
          mnorm_r <= mraw_r << lz_r;
          e_r     <= etop_r - exp_t'(lz_r);
          state_r <= ST_DENORM;
        end
        ST_DENORM: begin
          sden_r  <= mnorm_r >> dsh;
          lost_r  <= |(mnorm_r & ~({MW{1'b1}} << dsh));
          expf_r  <= dn_sub ? 8'd0 : 8'(e_r + exp_t'(127));
          ovf_r   <= (e_r > exp_t'(127));
          state_r <= ST_ROUND;
        end
        ST_ROUND: begin
          if (!phase_r) begin
            scale_r <= round_res;
            state_r <= ST_FMUL;
          end else begin
            result_r <= round_res;
            done_r   <= 1'b1;
            state_r  <= ST_IDLE;
          end
        end
        ST_FMUL: begin
          xmag_r  <= fm_prod;
          ymag_r  <= c_mant;
          tx_r    <= s_lsb + exp_t'(42);
          ty_r    <= c_lsb + exp_t'(24);
          psign_r <= fm_psign;
          asign_r <= req_r.acc[31];
          sign_r  <= fm_isign;
          spec_r  <= fm_nan ? SP_NAN : (fm_inf ? SP_INF : SP_NONE);
          state_r <= ST_ALIGN;
        end
        ST_ALIGN: begin
          a_r     <= shr_jam({xmag_r, 39'd0}, sat_sh(dx, 7'(WW)));
          b_r     <= shr_jam({ymag_r, 57'd0}, sat_sh(dy, 7'(WW)));
          t_r     <= t_max;
          state_r <= ST_ADD;
        end
        ST_ADD: begin
          mraw_r  <= add_res;
          etop_r  <= t_r;
          if (spec_r != SP_INF) sign_r <= add_sign;
          phase_r <= 1'b1;
          state_r <= ST_NORM;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign result = result_r;
endmodule

>>> rtl/q4_group16_int8_matvec_tile.sv
// top level: chain of eight row cells around one shared float unit
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Q4 x int8 matvec tile of eight weight rows. A chunk with neither half end nor
// tile end is added into the row dots and does not hold off the input. On a half
// end or a tile end the row chain rotates once through the float unit at its head,
// one row at a time, and the input is held off while the rotation runs. On a tile
// end the eight fp32 row sums then drain from the head of the chain, row 0 first,
// one per output transfer, and the sums are cleared to +0. A new chunk is taken
// while the last sum still waits at the output.
module q4_group16_int8_matvec_tile import q4mv_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // activations, weights_rows01, weights_rows23, weights_rows45, weights_rows67,
  // row_scales_lo, row_scales_hi, act_scale
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             in_tuser,   // half_end
  input  logic             in_tlast,   // tile_end
  output logic             out_tvalid,
  input  logic             out_tready,
  // row_index, row_sum, zero fill
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tlast   // tile_last
);
  typedef enum logic [1:0] {ST_IDLE, ST_FPU, ST_EMIT} state_t;

  state_t             state_r;
  logic [ROW_W-1:0]   row_r;
  logic               tile_r, fpu_go_r;
  logic [127:0]       scales_r;
  logic [31:0]        act_scale_r;
  logic               out_valid_r, out_last_r;
  logic [OUT_W-1:0]   out_data_r;

  link_t              chain [ROWS];
  link_t              tail_link;
  fpu_req_t           fpu_req;
  logic               fpu_done;
  logic [31:0]        fpu_result;
  logic               in_fire, emit_fire, shift_en;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign emit_fire = (state_r == ST_EMIT) && (!out_valid_r || out_tready);
  assign shift_en  = ((state_r == ST_FPU) && fpu_done) || emit_fire;

  // the tail takes the fresh accumulator, or zero while draining
  always_comb begin
    tail_link.dot = '0;
    tail_link.acc = (state_r == ST_EMIT) ? 32'd0 : fpu_result;
  end

  for (genvar r = 0; r < ROWS; r++) begin : g_row
    link_t nbr;
    if (r == ROWS - 1) begin : g_tail
      assign nbr = tail_link;
    end else begin : g_mid
      assign nbr = chain[r+1];
    end
    q4mv_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .add_en   (in_fire),
      .shift_en (shift_en),
      .acts     (in_tdata[63:0]),
      .wrow     (in_tdata[64 + 64*(r/2) + 32*(r%2) +: 32]),
      .link_in  (nbr),
      .link_out (chain[r])
    );
  end

  always_comb begin
    fpu_req.dot       = chain[0].dot;
    fpu_req.acc       = chain[0].acc;
    fpu_req.row_scale = scales_r[16*row_r +: 16];
    fpu_req.act_scale = act_scale_r;
  end

  q4mv_fpu u_fpu (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (fpu_go_r),
    .req    (fpu_req),
    .done   (fpu_done),
    .result (fpu_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_r       <= '0;
      tile_r      <= 1'b0;
      fpu_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      if (emit_fire) begin
        out_valid_r <= 1'b1;
        out_data_r  <= {{(OUT_W-32-ROW_W){1'b0}}, chain[0].acc, row_r};
        out_last_r  <= (row_r == ROW_W'(ROWS - 1));
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            scales_r    <= in_tdata[447:320];
            act_scale_r <= in_tdata[479:448];
            tile_r      <= in_tlast;
            row_r       <= '0;
            if (in_tuser || in_tlast) begin
              state_r  <= ST_FPU;
              fpu_go_r <= 1'b1;
            end
          end
        end
        ST_FPU: begin
          fpu_go_r <= fpu_done && (row_r != ROW_W'(ROWS - 1));
          if (fpu_done) begin
            row_r <= row_r + 1'b1;
            if (row_r == ROW_W'(ROWS - 1)) begin
              state_r <= tile_r ? ST_EMIT : ST_IDLE;
            end
          end
        end
        ST_EMIT: begin
          if (emit_fire) begin
            row_r <= row_r + 1'b1;
            if (row_r == ROW_W'(ROWS - 1)) state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `Q4MV_ASSERT_IMPL(a_fpu_done_in_fpu, fpu_done, state_r == ST_FPU)
  `Q4MV_ASSERT_NEXT(a_half_stalls_input, in_fire && (in_tuser || in_tlast), !in_tready)
  `Q4MV_ASSERT_IMPL(a_last_is_row7, out_tvalid && out_tlast, out_tdata[2:0] == 3'(ROWS - 1))
endmodule
